@@ rtl/rc_pulse_differential_mixer_macros.svh @@
// ----------------------------------------------------------------------------
// RC pulse mixer assertion macros
// Shared concurrent assertion forms for the mixer checkers.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_DIFFERENTIAL_MIXER_MACROS_SVH
`define RC_PULSE_DIFFERENTIAL_MIXER_MACROS_SVH

// assert a property on the rising clock edge, quiet during reset
`define RCPDM_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// assert a property on the rising clock edge, reset included
`define RCPDM_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/rcpdm_pkg.sv @@
// ----------------------------------------------------------------------------
// RC pulse mixer package
// Types, constants and the mix clamp shared by the mixer modules.
// ----------------------------------------------------------------------------
package rcpdm_pkg;

    localparam int CNT_W        = 8;
    localparam int WIDTH_W      = 8;
    localparam int CAP_SAT      = 255;
    localparam int ADDR_W       = 4;

    localparam logic [WIDTH_W-1:0] RST_MIN    = 8'd125;
    localparam logic [WIDTH_W-1:0] RST_MAX    = 8'd250;
    localparam logic [WIDTH_W-1:0] RST_CENTER = 8'd188;

    typedef enum logic [1:0] {
        REG_PULSE_MIN    = 2'd0,
        REG_PULSE_MAX    = 2'd1,
        REG_PULSE_CENTER = 2'd2,
        REG_OUTPUTS_EN   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic level_a;
        logic level_b;
    } in_item_t;

    typedef struct packed {
        logic               drive_a;
        logic               drive_b;
        logic [WIDTH_W-1:0] captured_a;
        logic [WIDTH_W-1:0] captured_b;
    } out_item_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] pulse_min;
        logic [WIDTH_W-1:0] pulse_max;
        logic [WIDTH_W-1:0] pulse_center;
        logic               outputs_enabled;
    } cfg_t;

    function automatic logic [WIDTH_W-1:0] clamp_mix(
        input logic signed [WIDTH_W+2:0] v,
        input logic [WIDTH_W-1:0]        lo,
        input logic [WIDTH_W-1:0]        hi
    );
        logic signed [WIDTH_W+2:0] r;
        r = v;
        if (r > $signed({3'b000, hi})) begin
            r = $signed({3'b000, hi});
        end
        if (r < $signed({3'b000, lo})) begin
            r = $signed({3'b000, lo});
        end
        return r[WIDTH_W-1:0];
    endfunction

endpackage

@@ rtl/rcpdm_engine.sv @@
// ----------------------------------------------------------------------------
// RC pulse mixer engine
// Per-channel timing state and the single-tick update of both channels.
// ----------------------------------------------------------------------------
module rcpdm_engine
    import rcpdm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic               act_reg  [2];
    logic               act_next [2];
    logic [CNT_W-1:0]   cnt_reg  [2];
    logic [CNT_W-1:0]   cnt_next [2];
    logic               run_reg  [2];
    logic               run_next [2];
    logic [WIDTH_W-1:0] cap_reg  [2];
    logic [WIDTH_W-1:0] cap_next [2];
    logic [WIDTH_W-1:0] cmp_reg  [2];
    logic [WIDTH_W-1:0] cmp_next [2];
    logic               drv_reg  [2];
    logic               drv_next [2];

    always_comb begin
        logic [CNT_W-1:0]          c;
        logic signed [WIDTH_W+2:0] d;
        logic [WIDTH_W-1:0]        mix [2];
        logic                      lvl [2];
        lvl[0] = item.level_a;
        lvl[1] = item.level_b;
        c      = '0;
        d      = '0;
        mix[0] = '0;
        mix[1] = '0;
        for (int ch = 0; ch < 2; ch++) begin
            act_next[ch] = act_reg[ch];
            cnt_next[ch] = cnt_reg[ch];
            run_next[ch] = run_reg[ch];
            cap_next[ch] = cap_reg[ch];
            cmp_next[ch] = cmp_reg[ch];
            drv_next[ch] = drv_reg[ch];
        end
        // advance running counters
        for (int ch = 0; ch < 2; ch++) begin
            if (step && run_reg[ch]) begin
                c            = cnt_reg[ch] + CNT_W'(1);
                cnt_next[ch] = c;
                if (c == CNT_W'(cmp_reg[ch])) begin
                    drv_next[ch] = 1'b0;
                end
                if (c == '0) begin
                    if (act_reg[ch]) begin
                        cap_next[ch] = cfg.pulse_max;
                    end
                    act_next[ch] = 1'b0;
                    drv_next[ch] = 1'b0;
                    run_next[ch] = 1'b0;
                end
            end
        end
        // check levels, A before B
        for (int ch = 0; ch < 2; ch++) begin
            d = $signed({3'b000, cap_next[1]}) - $signed({3'b000, cfg.pulse_center});
            mix[0] = clamp_mix($signed({3'b000, cap_next[0]}) + d,
                               cfg.pulse_min, cfg.pulse_max);
            mix[1] = clamp_mix($signed({3'b000, cap_next[0]}) - d,
                               cfg.pulse_min, cfg.pulse_max);
            if (step) begin
                if (!act_next[ch]) begin
                    if (lvl[ch]) begin
                        act_next[ch] = 1'b1;
                        cmp_next[ch] = mix[ch];
                        cnt_next[ch] = '0;
                        run_next[ch] = 1'b1;
                        if (cfg.outputs_enabled) begin
                            drv_next[ch] = 1'b1;
                        end
                    end
                end else if (!lvl[ch]) begin
                    act_next[ch] = 1'b0;
                    cap_next[ch] = (cnt_next[ch] > CNT_W'(CAP_SAT)) ?
                                   WIDTH_W'(CAP_SAT) : cnt_next[ch][WIDTH_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 2; ch++) begin
            if (!aresetn) begin
                act_reg[ch] <= 1'b0;
                cnt_reg[ch] <= '0;
                run_reg[ch] <= 1'b0;
                cap_reg[ch] <= RST_CENTER;
                cmp_reg[ch] <= RST_CENTER;
                drv_reg[ch] <= 1'b0;
            end else begin
                act_reg[ch] <= act_next[ch];
                cnt_reg[ch] <= cnt_next[ch];
                run_reg[ch] <= run_next[ch];
                cap_reg[ch] <= cap_next[ch];
                cmp_reg[ch] <= cmp_next[ch];
                drv_reg[ch] <= drv_next[ch];
            end
        end
    end

    assign result.drive_a    = drv_next[0];
    assign result.drive_b    = drv_next[1];
    assign result.captured_a = cap_next[0];
    assign result.captured_b = cap_next[1];

endmodule

@@ rtl/rc_pulse_differential_mixer.sv @@
// ----------------------------------------------------------------------------
// RC pulse differential mixer
// Times two RC pulse inputs per tick and drives two mixed output pulses.
// ----------------------------------------------------------------------------
// Result path: an accepted item is registered in the input register, then in the result register;
// Throughput: 1 item per cycle while the result side does not stall; the single-tick channel update sets this figure.
// Reset: synchronous active-low aresetn clears handshake state and channel state,
// loads register defaults; captured and compare widths restart at 188.
module rc_pulse_differential_mixer
    import rcpdm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t      cfg_reg;
    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      m_valid_reg;
    out_item_t result;
    logic      fire;
    reg_idx_t  idx;

    assign idx     = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pulse_min       <= RST_MIN;
            cfg_reg.pulse_max       <= RST_MAX;
            cfg_reg.pulse_center    <= RST_CENTER;
            cfg_reg.outputs_enabled <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_PULSE_MIN:    cfg_reg.pulse_min       <= pwdata[WIDTH_W-1:0];
                REG_PULSE_MAX:    cfg_reg.pulse_max       <= pwdata[WIDTH_W-1:0];
                REG_PULSE_CENTER: cfg_reg.pulse_center    <= pwdata[WIDTH_W-1:0];
                REG_OUTPUTS_EN:   cfg_reg.outputs_enabled <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PULSE_MIN:    prdata = {24'd0, cfg_reg.pulse_min};
            REG_PULSE_MAX:    prdata = {24'd0, cfg_reg.pulse_max};
            REG_PULSE_CENTER: prdata = {24'd0, cfg_reg.pulse_center};
            REG_OUTPUTS_EN:   prdata = {31'd0, cfg_reg.outputs_enabled};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg <= result;
        end
    end

    rcpdm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .item    (in_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

endmodule

@@ rtl/rcpdm_checker.sv @@
// ----------------------------------------------------------------------------
// RC pulse mixer checker
// Port-level checks of the mixer handshake, bound to the top level.
// ----------------------------------------------------------------------------
`include "rc_pulse_differential_mixer_macros.svh"

module rcpdm_checker
    import rcpdm_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data,
    input logic      pready
);

    `RCPDM_ASSERT_RST(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result item changed while stalled")
    `RCPDM_ASSERT_RST(a_stall, aclk, aresetn, !s_ready |-> m_valid && !$past(m_ready) || m_valid, "input stalled with result slot free")
    `RCPDM_ASSERT(a_reset, aclk, !aresetn |=> !m_valid, "result valid straight after reset")
    `RCPDM_ASSERT(a_pready, aclk, pready, "configuration port not ready")

endmodule

bind rc_pulse_differential_mixer rcpdm_checker u_rcpdm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

@@ tb/tb_rc_pulse_differential_mixer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC pulse differential mixer testbench
// Drives level pairs tick by tick through the input handshake and predicts
// both drive levels and captured widths per tick. Runs directed edges, then
// random pulse trains under several clamp, centre and enable settings, with
// random gaps and stalls, one long result hold-off and one mid-phase full drain.
// ----------------------------------------------------------------------------
module tb_rc_pulse_differential_mixer;
    import rcpdm_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 242;
    localparam int MAX_IDLE   = 13;
    localparam int HOLD_TICKS = 400;
    localparam int SETTLE     = 4;

    class mixer_scoreboard;
        logic [WIDTH_W-1:0] lo_clamp;
        logic [WIDTH_W-1:0] hi_clamp;
        logic [WIDTH_W-1:0] centre;
        logic               drive_en;
        logic               active [2];
        logic [CNT_W-1:0]   ticks [2];
        logic               running [2];
        logic [WIDTH_W-1:0] width [2];
        logic [WIDTH_W-1:0] compare [2];
        logic               drive [2];
        out_item_t          awaited_outputs [$];
        int                 fails;
        int                 seen;

        function new();
            lo_clamp = RST_MIN;
            hi_clamp = RST_MAX;
            centre   = RST_CENTER;
            drive_en = 1'b0;
            for (int ch = 0; ch < 2; ch++) begin
                active[ch]  = 1'b0;
                ticks[ch]   = '0;
                running[ch] = 1'b0;
                width[ch]   = RST_CENTER;
                compare[ch] = RST_CENTER;
                drive[ch]   = 1'b0;
            end
            fails = 0;
            seen  = 0;
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] word);
            case (idx)
                REG_PULSE_MIN:    lo_clamp = word[WIDTH_W-1:0];
                REG_PULSE_MAX:    hi_clamp = word[WIDTH_W-1:0];
                REG_PULSE_CENTER: centre   = word[WIDTH_W-1:0];
                REG_OUTPUTS_EN:   drive_en = word[0];
                default: ;
            endcase
        endfunction

        function logic [WIDTH_W-1:0] clamp_width(int v);
            int r;
            r = v;
            if (r > int'(hi_clamp)) r = int'(hi_clamp);
            if (r < int'(lo_clamp)) r = int'(lo_clamp);
            return r[WIDTH_W-1:0];
        endfunction

        function void count_tick(int ch);
            if (!running[ch]) return;
            ticks[ch] = ticks[ch] + 1'b1;
            if (ticks[ch] == compare[ch]) drive[ch] = 1'b0;
            if (ticks[ch] == '0) begin
                if (active[ch]) width[ch] = hi_clamp;
                active[ch]  = 1'b0;
                drive[ch]   = 1'b0;
                running[ch] = 1'b0;
            end
        endfunction

        function void sample_level(int ch, logic level);
            int sum_w;
            int diff;
            if (!active[ch]) begin
                if (level) begin
                    diff  = int'(width[1]) - int'(centre);
                    sum_w = (ch == 0) ? int'(width[0]) + diff : int'(width[0]) - diff;
                    active[ch]  = 1'b1;
                    compare[ch] = clamp_width(sum_w);
                    ticks[ch]   = '0;
                    running[ch] = 1'b1;
                    if (drive_en) drive[ch] = 1'b1;
                end
            end else if (!level) begin
                active[ch] = 1'b0;
                width[ch]  = (ticks[ch] > CAP_SAT) ? WIDTH_W'(CAP_SAT) : WIDTH_W'(ticks[ch]);
            end
        endfunction

        function void note_tick(in_item_t d);
            out_item_t o;
            count_tick(0);
            count_tick(1);
            sample_level(0, d.level_a);
            sample_level(1, d.level_b);
            o.drive_a    = drive[0];
            o.drive_b    = drive[1];
            o.captured_a = width[0];
            o.captured_b = width[1];
            awaited_outputs.push_back(o);
        endfunction

        function void check_output(out_item_t got);
            out_item_t want;
            logic bad;
            seen++;
            if (awaited_outputs.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("output %0d arrived with nothing awaited: %p", seen, got);
                return;
            end
            want = awaited_outputs.pop_front();
            bad  = 1'b0;
            if (got.drive_a !== want.drive_a) bad = 1'b1;
            if (got.drive_b !== want.drive_b) bad = 1'b1;
            if (got.captured_a !== want.captured_a) bad = 1'b1;
            if (got.captured_b !== want.captured_b) bad = 1'b1;
            if (bad) begin
                fails++;
                if (fails <= 10)
                    $display("output %0d: exp drv %b%b cap %0d/%0d, got drv %b%b cap %0d/%0d",
                             seen, want.drive_a, want.drive_b, want.captured_a,
                             want.captured_b, got.drive_a, got.drive_b,
                             got.captured_a, got.captured_b);
            end
        endfunction

        function int pending();
            return awaited_outputs.size();
        endfunction
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    mixer_scoreboard sb;
    int              hold_off_ticks = 0;
    logic            tx_calm = 1'b0;
    int              run_left [2] = '{0, 0};
    logic            run_high [2] = '{1'b0, 1'b0};

    rc_pulse_differential_mixer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic write_reg(reg_idx_t idx, logic [WIDTH_W-1:0] v);
        logic [31:0] word;
        word = $urandom;
        if (idx == REG_OUTPUTS_EN) word[0] = v[0];
        else word[WIDTH_W-1:0] = v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drive_tick(in_item_t d);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(d);
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function in_item_t next_levels();
        in_item_t d;
        logic     lv [2];
        int       r;
        for (int ch = 0; ch < 2; ch++) begin
            if (run_left[ch] == 0) begin
                run_high[ch] = !run_high[ch];
                r = $urandom_range(0, 99);
                if (run_high[ch])
                    run_left[ch] = (r < 8)  ? $urandom_range(250, 270) :
                                   (r < 25) ? $urandom_range(1, 3) : $urandom_range(1, 60);
                else
                    run_left[ch] = (r < 6) ? $urandom_range(200, 300) : $urandom_range(1, 40);
            end
            run_left[ch]--;
            lv[ch] = run_high[ch];
        end
        d.level_a = lv[0];
        d.level_b = lv[1];
        if ($urandom_range(0, 99) < 8) begin
            d.level_a = $urandom_range(0, 1);
            d.level_b = $urandom_range(0, 1);
        end
        return d;
    endfunction

    initial begin : result_sink
        int   stall;
        logic rx_calm;
        rx_calm = 1'b1;
        forever begin
            if (hold_off_ticks > 0) begin
                stall = hold_off_ticks;
                hold_off_ticks = 0;
            end else begin
                stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_output(m_data);
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        end
    end

    initial begin : stimulus
        in_item_t opening [16];
        cfg_t     phase_cfg [PHASES];
        sb = new();
        opening = '{'{1'b0, 1'b0}, '{1'b1, 1'b1}, '{1'b1, 1'b1}, '{1'b1, 1'b1},
                    '{1'b0, 1'b1}, '{1'b1, 1'b0}, '{1'b0, 1'b0}, '{1'b1, 1'b0},
                    '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b1}, '{1'b0, 1'b0},
                    '{1'b0, 1'b0}, '{1'b0, 1'b1}, '{1'b0, 1'b1}, '{1'b0, 1'b0}};
        phase_cfg[0] = '{RST_MIN, RST_MAX, RST_CENTER, 1'b1};
        phase_cfg[1] = '{8'd0, 8'd255, 8'd0, 1'b1};
        phase_cfg[2] = '{8'd10, 8'd40, 8'd20, 1'b1};
        phase_cfg[3] = '{8'd255, 8'd0, 8'd255, 1'b1};
        phase_cfg[4] = '{8'd0, 8'd0, 8'd128, 1'b1};
        phase_cfg[5] = '{8'd5, 8'd30, 8'd15, 1'b0};
        phase_cfg[6] = '{WIDTH_W'($urandom), WIDTH_W'($urandom), WIDTH_W'($urandom), 1'b1};
        phase_cfg[7] = '{WIDTH_W'($urandom_range(0, 60)), WIDTH_W'($urandom_range(20, 120)),
                         WIDTH_W'($urandom), 1'b1};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(REG_OUTPUTS_EN, 8'd1);
        foreach (opening[i]) drive_tick(opening[i]);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_PULSE_MIN, phase_cfg[p].pulse_min);
            write_reg(REG_PULSE_MAX, phase_cfg[p].pulse_max);
            write_reg(REG_PULSE_CENTER, phase_cfg[p].pulse_center);
            write_reg(REG_OUTPUTS_EN, WIDTH_W'(phase_cfg[p].outputs_enabled));
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (p == 2 && i == 40) hold_off_ticks = HOLD_TICKS;
                if (p == 4 && i == 120) settle();
                drive_tick(next_levels());
            end
        end

        settle();
        repeat (10) @(posedge aclk);
        sb.fails += sb.pending();
        if (sb.fails == 0) begin
            $display("tb_rc_pulse_differential_mixer: clean");
        end else begin
            $display("tb_rc_pulse_differential_mixer: errors");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("tb_rc_pulse_differential_mixer: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rcpdm_pkg.sv
rtl/rcpdm_engine.sv
rtl/rc_pulse_differential_mixer.sv
rtl/rcpdm_checker.sv
tb/tb_rc_pulse_differential_mixer.sv
